// ===== design/assert_macros.svh =====
// assertion macros for the trie lookup block
// no dependencies; assertions compile away when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("btlpm assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btlpm assertion failed");
// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btlpm assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/btlpm_pkg.sv =====
// shared types, constants and codes for the binary trie prefix-match block
// no dependencies; used by every module of the block but the generic ram
package btlpm_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = NODE_W + 1;
    localparam int TOP_W      = NODE_W + 1;
    localparam int ADDR_W     = 32;
    localparam int ABIT_W     = $clog2(ADDR_W);
    localparam int LEN_W      = 6;
    localparam int VAL_W      = 32;

    localparam logic [LEN_W-1:0] ADDR_BITS = LEN_W'(ADDR_W);

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_length;
        logic [VAL_W-1:0]  entry_value;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        logic             matched;
        logic [1:0]       status;
    } rsp_t;

    // one trie node as held in the node memory
    typedef struct packed {
        logic [NODE_W-1:0] child_zero;
        logic [NODE_W-1:0] child_one;
        logic              mark;
        logic [CNT_W-1:0]  use_count;
        logic [VAL_W-1:0]  value;
    } node_t;

    localparam int NODE_REC_W = $bits(node_t);

    // node memory read source
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_NODE  = 2'd1,
        RD_CHILD = 2'd2,
        RD_PAR   = 2'd3
    } rd_t;

    // node memory write kind
    typedef enum logic [3:0] {
        NW_NONE     = 4'd0,
        NW_CLEAR    = 4'd1,
        NW_VALUE    = 4'd2,
        NW_INC      = 4'd3,
        NW_INC_MARK = 4'd4,
        NW_INC_LINK = 4'd5,
        NW_FRESH    = 4'd6,
        NW_DEC      = 4'd7,
        NW_UNLINK   = 4'd8
    } nw_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       start;
        logic       restart;
        rd_t        rd;
        nw_t        nw;
        logic       adv_next;
        logic       adv_alloc;
        logic       fs_pop_rd;
        logic       fs_pop;
        logic       fs_push;
        logic       latch_next;
        logic       look_eval;
        logic       set_status;
        logic [1:0] status_val;
        logic       load_rsp;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic              clr_last;
        logic              is_ins;
        logic              is_lkp;
        logic              is_del;
        logic              at_end;
        logic              child_nil;
        logic              mark;
        logic              too_many;
        logic              now_free;
        logic              freed;
        logic              rsp_free;
        logic [TOP_W-1:0]  free_top;
        logic [NODE_W-1:0] alloc;
    } stat_t;

endpackage

// ===== design/btlpm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module btlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/btlpm_dp.sv =====
// datapath: node memory, free stack, walk registers and result register
// depends on btlpm_pkg and btlpm_ram
module btlpm_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  btlpm_pkg::req_t  req_data,
    input  btlpm_pkg::ctrl_t ctl,
    input  logic             rsp_stall,
    output logic             rsp_valid,
    output btlpm_pkg::rsp_t  rsp_data,
    output btlpm_pkg::stat_t stat
);

    logic [1:0]                       cmd_reg;
    logic [btlpm_pkg::ADDR_W-1:0]     addr_reg;
    logic [btlpm_pkg::LEN_W-1:0]      len_reg;
    logic [btlpm_pkg::VAL_W-1:0]      val_reg;
    logic [btlpm_pkg::NODE_W-1:0]     node_reg;
    logic [btlpm_pkg::NODE_W-1:0]     par_reg;
    logic [btlpm_pkg::NODE_W-1:0]     next_reg;
    logic [btlpm_pkg::NODE_W-1:0]     alloc_reg;
    logic [btlpm_pkg::LEN_W-1:0]      depth_reg;
    logic [btlpm_pkg::TOP_W-1:0]      free_top_reg;
    logic [btlpm_pkg::NODE_W-1:0]     clr_cnt_reg;
    logic [btlpm_pkg::VAL_W-1:0]      res_reg;
    logic                             hit_reg;
    logic [1:0]                       status_reg;
    logic                             freed_reg;
    logic                             rsp_valid_reg;
    btlpm_pkg::rsp_t                  rsp_reg;

    logic [btlpm_pkg::NODE_REC_W-1:0] node_rdata;
    btlpm_pkg::node_t                 rec;
    btlpm_pkg::node_t                 wr_rec;
    logic                             node_wr_en;
    logic [btlpm_pkg::NODE_W-1:0]     node_wr_addr;
    logic                             node_rd_en;
    logic [btlpm_pkg::NODE_W-1:0]     node_rd_addr;

    logic [btlpm_pkg::NODE_W-1:0]     fs_rdata;
    logic                             fs_wr_en;
    logic [btlpm_pkg::NODE_W-1:0]     fs_wr_addr;
    logic [btlpm_pkg::NODE_W-1:0]     fs_wr_data;

    logic [btlpm_pkg::ABIT_W-1:0]     idx_cur;
    logic [btlpm_pkg::ABIT_W-1:0]     idx_prev;
    logic                             bit_cur;
    logic                             bit_prev;
    logic [btlpm_pkg::NODE_W-1:0]     child_cur;
    logic                             at_end;
    logic                             top_room;
    logic [btlpm_pkg::LEN_W-1:0]      len_in;

    assign rec = btlpm_pkg::node_t'(node_rdata);

    // address bit at the current and the parent depth, most significant first
    assign idx_cur   = btlpm_pkg::ABIT_W'(btlpm_pkg::ADDR_W - 1)
                       - depth_reg[btlpm_pkg::ABIT_W-1:0];
    assign idx_prev  = idx_cur + btlpm_pkg::ABIT_W'(1);
    assign bit_cur   = addr_reg[idx_cur];
    assign bit_prev  = addr_reg[idx_prev];
    assign child_cur = bit_cur ? rec.child_one : rec.child_zero;
    assign at_end    = (depth_reg == len_reg);
    assign top_room  = (free_top_reg < btlpm_pkg::TOP_W'(btlpm_pkg::NODE_COUNT));

    // prefix length saturates; lookup takes the full address as its length
    always_comb
    begin
        if (req_data.command == btlpm_pkg::CMD_LOOKUP)
        begin
            len_in = btlpm_pkg::ADDR_BITS;
        end
        else if (req_data.prefix_length > btlpm_pkg::ADDR_BITS)
        begin
            len_in = btlpm_pkg::ADDR_BITS;
        end
        else
        begin
            len_in = req_data.prefix_length;
        end
    end

    // status towards the controller
    always_comb
    begin
        stat.clr_last  = (clr_cnt_reg == '1);
        stat.is_ins    = (cmd_reg == btlpm_pkg::CMD_INSERT);
        stat.is_lkp    = (cmd_reg == btlpm_pkg::CMD_LOOKUP);
        stat.is_del    = (cmd_reg == btlpm_pkg::CMD_DELETE);
        stat.at_end    = at_end;
        stat.child_nil = (child_cur == '0);
        stat.mark      = rec.mark;
        stat.too_many  = (btlpm_pkg::TOP_W'(len_reg - depth_reg) > free_top_reg);
        stat.now_free  = (depth_reg != '0) && (rec.use_count == btlpm_pkg::CNT_W'(1));
        stat.freed     = freed_reg;
        stat.rsp_free  = !rsp_valid_reg || !rsp_stall;
        stat.free_top  = free_top_reg;
        stat.alloc     = alloc_reg;
    end

    // node memory read address
    always_comb
    begin
        node_rd_en   = 1'b1;
        node_rd_addr = node_reg;
        case (ctl.rd)
            btlpm_pkg::RD_NODE:  node_rd_addr = node_reg;
            btlpm_pkg::RD_CHILD: node_rd_addr = child_cur;
            btlpm_pkg::RD_PAR:   node_rd_addr = par_reg;
            default:             node_rd_en   = 1'b0;
        endcase
    end

    // node memory write: read-modify-write of the record just read, or a fresh record when clearing or allocating
    always_comb
    begin
        node_wr_en   = 1'b1;
        node_wr_addr = node_reg;
        wr_rec       = rec;
        case (ctl.nw)
            btlpm_pkg::NW_CLEAR:
            begin
                node_wr_addr     = clr_cnt_reg;
                wr_rec           = '0;
                wr_rec.use_count = btlpm_pkg::CNT_W'(clr_cnt_reg == '0);
            end
            btlpm_pkg::NW_VALUE:
            begin
                wr_rec.value = val_reg;
            end
            btlpm_pkg::NW_INC:
            begin
                wr_rec.use_count = rec.use_count + btlpm_pkg::CNT_W'(1);
            end
            btlpm_pkg::NW_INC_MARK:
            begin
                wr_rec.use_count = rec.use_count + btlpm_pkg::CNT_W'(1);
                wr_rec.mark      = 1'b1;
                wr_rec.value     = val_reg;
            end
            btlpm_pkg::NW_INC_LINK:
            begin
                wr_rec.use_count = rec.use_count + btlpm_pkg::CNT_W'(1);
                if (bit_cur)
                begin
                    wr_rec.child_one = fs_rdata;
                end
                else
                begin
                    wr_rec.child_zero = fs_rdata;
                end
            end
            btlpm_pkg::NW_FRESH:
            begin
                node_wr_addr = alloc_reg;
                wr_rec       = '0;
            end
            btlpm_pkg::NW_DEC:
            begin
                // the root keeps one user of its own
                if ((depth_reg != '0) || (rec.use_count > btlpm_pkg::CNT_W'(1)))
                begin
                    wr_rec.use_count = rec.use_count - btlpm_pkg::CNT_W'(1);
                end
                if (at_end)
                begin
                    wr_rec.mark = 1'b0;
                end
            end
            btlpm_pkg::NW_UNLINK:
            begin
                node_wr_addr = par_reg;
                if (bit_prev)
                begin
                    wr_rec.child_one = '0;
                end
                else
                begin
                    wr_rec.child_zero = '0;
                end
            end
            default:
            begin
                node_wr_en = 1'b0;
                wr_rec     = '0;
            end
        endcase
    end

    // free stack write: fill during clearing, push on delete
    always_comb
    begin
        if (ctl.nw == btlpm_pkg::NW_CLEAR)
        begin
            fs_wr_en   = 1'b1;
            fs_wr_addr = clr_cnt_reg;
            fs_wr_data = clr_cnt_reg + btlpm_pkg::NODE_W'(1);
        end
        else
        begin
            fs_wr_en   = ctl.fs_push && top_room;
            fs_wr_addr = free_top_reg[btlpm_pkg::NODE_W-1:0];
            fs_wr_data = node_reg;
        end
    end

    btlpm_ram #(
        .WIDTH (btlpm_pkg::NODE_REC_W),
        .DEPTH (btlpm_pkg::NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (wr_rec),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rdata)
    );

    btlpm_ram #(
        .WIDTH (btlpm_pkg::NODE_W),
        .DEPTH (btlpm_pkg::NODE_COUNT)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (fs_wr_en),
        .wr_addr (fs_wr_addr),
        .wr_data (fs_wr_data),
        .rd_en   (ctl.fs_pop_rd),
        .rd_addr (btlpm_pkg::NODE_W'(free_top_reg - btlpm_pkg::TOP_W'(1))),
        .rd_data (fs_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            free_top_reg  <= btlpm_pkg::TOP_W'(btlpm_pkg::NODE_COUNT - 1);
            clr_cnt_reg   <= '0;
            freed_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start || ctl.restart)
            begin
                depth_reg <= '0;
                freed_reg <= 1'b0;
            end
            else if ((ctl.rd == btlpm_pkg::RD_CHILD) || ctl.adv_next || ctl.adv_alloc)
            begin
                depth_reg <= depth_reg + btlpm_pkg::LEN_W'(1);
            end
            if (ctl.fs_push)
            begin
                freed_reg <= 1'b1;
                if (top_room)
                begin
                    free_top_reg <= free_top_reg + btlpm_pkg::TOP_W'(1);
                end
            end
            else if (ctl.fs_pop)
            begin
                free_top_reg <= free_top_reg - btlpm_pkg::TOP_W'(1);
            end
            if (ctl.nw == btlpm_pkg::NW_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + btlpm_pkg::NODE_W'(1);
            end
            if (ctl.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // walk and payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg    <= req_data.command;
            addr_reg   <= req_data.address;
            len_reg    <= len_in;
            val_reg    <= req_data.entry_value;
            res_reg    <= '0;
            hit_reg    <= 1'b0;
            status_reg <= btlpm_pkg::ST_DONE;
        end
        if (ctl.start || ctl.restart)
        begin
            node_reg <= '0;
            par_reg  <= '0;
        end
        else if (ctl.rd == btlpm_pkg::RD_CHILD)
        begin
            par_reg  <= node_reg;
            node_reg <= child_cur;
        end
        else if (ctl.adv_next)
        begin
            par_reg  <= node_reg;
            node_reg <= next_reg;
        end
        else if (ctl.adv_alloc)
        begin
            node_reg <= alloc_reg;
        end
        if (ctl.latch_next)
        begin
            next_reg <= child_cur;
        end
        if (ctl.fs_pop)
        begin
            alloc_reg <= fs_rdata;
        end
        // deepest marked node below the root wins
        if (ctl.look_eval && (depth_reg != '0) && rec.mark)
        begin
            res_reg <= rec.value;
            hit_reg <= 1'b1;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status_val;
        end
        if (ctl.load_rsp)
        begin
            rsp_reg.result_value <= res_reg;
            rsp_reg.matched      <= hit_reg;
            rsp_reg.status       <= status_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// ===== design/btlpm_ctrl.sv =====
// controller state machine sequencing clearing, walks, insert and delete
// depends on btlpm_pkg
module btlpm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  btlpm_pkg::stat_t stat,
    output logic             req_stall,
    output btlpm_pkg::ctrl_t ctl
);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_W1R     = 13'b0000000000100,
        S_W1D     = 13'b0000000001000,
        S_INS_R   = 13'b0000000010000,
        S_INS_D   = 13'b0000000100000,
        S_INS_POP = 13'b0000001000000,
        S_INS_NEW = 13'b0000010000000,
        S_DEL_R   = 13'b0000100000000,
        S_DEL_D   = 13'b0001000000000,
        S_DEL_PR  = 13'b0010000000000,
        S_DEL_PW  = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.rd         = btlpm_pkg::RD_NONE;
        ctl.nw         = btlpm_pkg::NW_NONE;
        ctl.status_val = btlpm_pkg::ST_DONE;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.nw = btlpm_pkg::NW_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = S_W1R;
                end
            end
            S_W1R:
            begin
                if (!(stat.is_ins || stat.is_lkp || stat.is_del))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.rd     = btlpm_pkg::RD_NODE;
                    state_next = S_W1D;
                end
            end
            // first walk: lookup, presence check, free node count check
            S_W1D:
            begin
                if (stat.is_lkp)
                begin
                    ctl.look_eval = 1'b1;
                    if (stat.at_end || stat.child_nil)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctl.rd = btlpm_pkg::RD_CHILD;
                    end
                end
                else if (stat.is_ins)
                begin
                    if (stat.at_end && stat.mark)
                    begin
                        ctl.nw     = btlpm_pkg::NW_VALUE;
                        state_next = S_FIN;
                    end
                    else if (stat.at_end)
                    begin
                        ctl.restart = 1'b1;
                        state_next  = S_INS_R;
                    end
                    else if (stat.child_nil && stat.too_many)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status_val = btlpm_pkg::ST_FULL;
                        state_next     = S_FIN;
                    end
                    else if (stat.child_nil)
                    begin
                        ctl.restart = 1'b1;
                        state_next  = S_INS_R;
                    end
                    else
                    begin
                        ctl.rd = btlpm_pkg::RD_CHILD;
                    end
                end
                else
                begin
                    if ((stat.at_end && !stat.mark) || (!stat.at_end && stat.child_nil))
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status_val = btlpm_pkg::ST_ABSENT;
                        state_next     = S_FIN;
                    end
                    else if (stat.at_end)
                    begin
                        ctl.restart = 1'b1;
                        state_next  = S_DEL_R;
                    end
                    else
                    begin
                        ctl.rd = btlpm_pkg::RD_CHILD;
                    end
                end
            end
            S_INS_R:
            begin
                ctl.rd     = btlpm_pkg::RD_NODE;
                state_next = S_INS_D;
            end
            // insert pass: count users, allocate missing nodes, mark the last
            S_INS_D:
            begin
                if (stat.at_end)
                begin
                    ctl.nw     = btlpm_pkg::NW_INC_MARK;
                    state_next = S_FIN;
                end
                else if (stat.child_nil)
                begin
                    ctl.fs_pop_rd = 1'b1;
                    state_next    = S_INS_POP;
                end
                else
                begin
                    ctl.nw = btlpm_pkg::NW_INC;
                    ctl.rd = btlpm_pkg::RD_CHILD;
                end
            end
            S_INS_POP:
            begin
                ctl.nw     = btlpm_pkg::NW_INC_LINK;
                ctl.fs_pop = 1'b1;
                state_next = S_INS_NEW;
            end
            S_INS_NEW:
            begin
                ctl.nw        = btlpm_pkg::NW_FRESH;
                ctl.adv_alloc = 1'b1;
                state_next    = S_INS_R;
            end
            S_DEL_R:
            begin
                ctl.rd     = btlpm_pkg::RD_NODE;
                state_next = S_DEL_D;
            end
            // delete pass, top down: drop users and free unused nodes
            S_DEL_D:
            begin
                ctl.nw         = btlpm_pkg::NW_DEC;
                ctl.latch_next = 1'b1;
                ctl.fs_push    = stat.now_free;
                if (stat.now_free && !stat.freed)
                begin
                    state_next = S_DEL_PR;
                end
                else if (stat.at_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.rd = btlpm_pkg::RD_CHILD;
                end
            end
            // unlink the first freed node from its surviving parent
            S_DEL_PR:
            begin
                ctl.rd     = btlpm_pkg::RD_PAR;
                state_next = S_DEL_PW;
            end
            S_DEL_PW:
            begin
                ctl.nw = btlpm_pkg::NW_UNLINK;
                if (stat.at_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.adv_next = 1'b1;
                    state_next   = S_DEL_R;
                end
            end
            S_FIN:
            begin
                if (stat.rsp_free)
                begin
                    ctl.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/binary_trie_longest_prefix_match_core.sv =====
// top level of the binary trie longest prefix match table
// depends on btlpm_pkg, btlpm_ctrl, btlpm_dp and assert_macros.svh
//
// Usage: one request channel (req_valid, req_stall, req_data) carries insert,
// lookup and delete commands; one response channel (rsp_valid, rsp_stall,
// rsp_data) returns exactly one response per request, in order. A transaction
// completes at a clock edge with valid high and stall low.
// Requests are handled one at a time. Each trie level costs one node memory
// access, and the single node memory port sets the pace:
//   lookup  : one walk down the levels of the address to the response register
//   insert  : a check walk, then a second pass over the existing nodes
//             that also allocates each missing node
//   delete  : a check walk, then a second pass, plus one unlink of the
//             first freed node from its parent
// After reset the block runs a clearing pass over the node
// memory and the free stack; req_stall stays high during it.
// The response register frees the engine: a finished response waits there
// while rsp_stall is high, and the next request is taken meanwhile; its own
// response is held in the engine until the register empties.
`include "assert_macros.svh"
module binary_trie_longest_prefix_match_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  btlpm_pkg::req_t req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output btlpm_pkg::rsp_t rsp_data
);

    btlpm_pkg::ctrl_t ctl;
    btlpm_pkg::stat_t stat;
    logic             pool_ok;
    logic             rsp_hit;

    btlpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .req_stall (req_stall),
        .ctl       (ctl)
    );

    btlpm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .ctl       (ctl),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .stat      (stat)
    );

    // terms used by the checks below
    assign pool_ok = (stat.free_top <= btlpm_pkg::TOP_W'(btlpm_pkg::NODE_COUNT - 1));
    assign rsp_hit = rsp_valid && rsp_data.matched;

    // free pool never holds more than every non-root node
    `ASSERT_ALWAYS(a_free_top_range, clk, rst_n, pool_ok)
    // the root is never handed out of the free stack
    `ASSERT_IMPLY(a_alloc_not_root, clk, rst_n, ctl.nw == btlpm_pkg::NW_FRESH, stat.alloc != '0)
    // a match only comes from a lookup, which always completes
    `ASSERT_IMPLY(a_match_done, clk, rst_n, rsp_hit, rsp_data.status == btlpm_pkg::ST_DONE)
    // one request in the engine at a time
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && !req_stall, req_stall)

endmodule
